// File: rtl/core/tswr_pkg.sv
// ----------------------------------------------------------------------------
// tswr_pkg
// Types and constants shared by the send window ring controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tswr_pkg;

  localparam int CNT_W  = 13;
  localparam int OFFS_W = 12;
  localparam int BYTE_W = 8;

  localparam logic [CNT_W-1:0] BUF_SIZE_RESET = 13'd4096;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_READ   = 2'd1,
    MODE_DROP   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SEL_WRITE,
    SEL_READ,
    SEL_DROP
  } mod_sel_t;

  typedef struct packed {
    logic     load;
    logic     mod_start;
    mod_sel_t mod_sel;
    logic     commit_append;
    logic     commit_drop;
    logic     mem_read;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  room;
    logic  mod_busy;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/tswr_ram.sv
// ----------------------------------------------------------------------------
// tswr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tswr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tswr_mod.sv
// ----------------------------------------------------------------------------
// tswr_mod
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tswr_mod #(
  parameter int XW = 17
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [XW-1:0]             x,
  input  wire logic [tswr_pkg::CNT_W-1:0] divisor,
  output logic                           busy,
  output logic      [tswr_pkg::CNT_W-1:0] rem
);

  localparam int CW = (XW > 1) ? $clog2(XW) : 1;

  logic [XW-1:0]            x_sh;
  logic [CW-1:0]            cnt;
  logic [tswr_pkg::CNT_W:0] rem_sh;
  logic [tswr_pkg::CNT_W:0] rem_sub;

  // The remainder always stays below the divisor, so the shifted value is
  // below twice the divisor and one conditional subtract restores it.
  assign rem_sh  = {rem, x_sh[XW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_sh <= x;
      rem  <= '0;
      cnt  <= CW'(XW - 1);
    end else if (busy) begin
      x_sh <= x_sh << 1;
      cnt  <= cnt - 1'b1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= rem_sub[tswr_pkg::CNT_W-1:0];
      end else begin
        rem <= rem_sh[tswr_pkg::CNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tswr_dp.sv
// ----------------------------------------------------------------------------
// tswr_dp
// Datapath: indices, byte count, size register, modulo unit, byte store and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tswr_dp #(
  parameter int DEPTH = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tswr_pkg::cmd_t              cmd,
  output tswr_pkg::stat_t                  stat,
  input  wire logic                        cfg_we,
  input  wire logic [tswr_pkg::CNT_W-1:0]  buffer_size,
  input  wire logic [1:0]                  mode,
  input  wire logic [tswr_pkg::BYTE_W-1:0] write_byte,
  input  wire logic [tswr_pkg::OFFS_W-1:0] read_offset,
  input  wire logic [tswr_pkg::CNT_W-1:0]  amount,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic      [tswr_pkg::BYTE_W-1:0] read_data,
  output logic                             accepted,
  output logic      [tswr_pkg::CNT_W-1:0]  stored_count,
  output logic                             full_res,
  output logic                             post_output,
  output logic                             overrun
);

  localparam int AW = $clog2(DEPTH);
  localparam int XW = ((AW > tswr_pkg::CNT_W) ? AW : tswr_pkg::CNT_W) + 1;

  logic [tswr_pkg::CNT_W-1:0]  size_reg;
  logic [tswr_pkg::CNT_W-1:0]  size_eff;
  logic [AW-1:0]               write_index;
  logic [AW-1:0]               read_index;
  logic [tswr_pkg::CNT_W-1:0]  byte_count;

  tswr_pkg::mode_t             mode_q;
  logic [tswr_pkg::BYTE_W-1:0] wbyte_q;
  logic [tswr_pkg::OFFS_W-1:0] offs_q;
  logic [tswr_pkg::CNT_W-1:0]  drop_q;
  logic                        ovr_q;
  logic                        acc_q;

  logic [XW-1:0]               mod_x;
  logic                        mod_busy;
  logic [tswr_pkg::CNT_W-1:0]  mod_rem;
  logic [tswr_pkg::CNT_W:0]    pos_inc;
  logic [AW-1:0]               pos;
  logic [tswr_pkg::BYTE_W-1:0] ram_rdata;

  // A size of zero acts as one; a size past the store depth acts as the depth.
  always_comb begin
    if (size_reg == '0) begin
      size_eff = tswr_pkg::CNT_W'(1);
    end else if (32'(size_reg) > 32'(DEPTH)) begin
      size_eff = tswr_pkg::CNT_W'(DEPTH);
    end else begin
      size_eff = size_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= tswr_pkg::BUF_SIZE_RESET;
    end else if (cfg_we) begin
      size_reg <= buffer_size;
    end
  end

  // Adding before the reduction gives the same remainder as reducing the
  // index first, so one pass of the modulo unit covers each access.
  always_comb begin
    unique case (cmd.mod_sel)
      tswr_pkg::SEL_WRITE: mod_x = XW'(write_index);
      tswr_pkg::SEL_READ:  mod_x = XW'(read_index) + XW'(offs_q);
      tswr_pkg::SEL_DROP:  mod_x = XW'(read_index) + XW'(drop_q);
      default:             mod_x = '0;
    endcase
  end

  tswr_mod #(
    .XW (XW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mod_start),
    .x       (mod_x),
    .divisor (size_eff),
    .busy    (mod_busy),
    .rem     (mod_rem)
  );

  assign pos     = AW'(mod_rem);
  assign pos_inc = {1'b0, mod_rem} + 1'b1;

  tswr_ram #(
    .WIDTH (tswr_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit_append),
    .waddr (pos),
    .wdata (wbyte_q),
    .re    (cmd.mem_read),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= tswr_pkg::mode_t'(mode);
      wbyte_q <= write_byte;
      offs_q  <= read_offset;
      if (amount > byte_count) begin
        drop_q <= byte_count;
        ovr_q  <= 1'b1;
      end else begin
        drop_q <= amount;
        ovr_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      byte_count  <= '0;
      acc_q       <= 1'b0;
    end else begin
      if (cmd.load) begin
        acc_q <= 1'b0;
      end
      if (cmd.commit_append) begin
        acc_q      <= 1'b1;
        byte_count <= byte_count + 1'b1;
        if (pos_inc == {1'b0, size_eff}) begin
          write_index <= '0;
        end else begin
          write_index <= AW'(pos_inc);
        end
      end
      if (cmd.commit_drop) begin
        read_index <= pos;
        byte_count <= byte_count - drop_q;
      end
    end
  end

  // Output register: holds one result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data    <= (mode_q == tswr_pkg::MODE_READ) ? ram_rdata : '0;
      accepted     <= (mode_q == tswr_pkg::MODE_APPEND) && acc_q;
      stored_count <= byte_count;
      full_res     <= byte_count >= size_eff;
      post_output  <= (mode_q == tswr_pkg::MODE_DROP) && (byte_count != '0);
      overrun      <= (mode_q == tswr_pkg::MODE_DROP) && ovr_q;
    end
  end

  assign stat.mode     = mode_q;
  assign stat.room     = byte_count < size_eff;
  assign stat.mod_busy = mod_busy;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// File: rtl/core/tswr_ctrl.sv
// ----------------------------------------------------------------------------
// tswr_ctrl
// Controller: sequences one operation through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tswr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output tswr_pkg::cmd_t       cmd,
  input  wire tswr_pkg::stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_MOD,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (stat.mode)
      tswr_pkg::MODE_APPEND: cmd.mod_sel = tswr_pkg::SEL_WRITE;
      tswr_pkg::MODE_READ:   cmd.mod_sel = tswr_pkg::SEL_READ;
      default:               cmd.mod_sel = tswr_pkg::SEL_DROP;
    endcase
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        // A full buffer rejects an append, and the unused mode does nothing.
        if ((stat.mode == tswr_pkg::MODE_APPEND && !stat.room) ||
            stat.mode == tswr_pkg::MODE_NONE) begin
          state_next = S_FIN;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        if (!stat.mod_busy) begin
          unique case (stat.mode)
            tswr_pkg::MODE_APPEND: cmd.commit_append = 1'b1;
            tswr_pkg::MODE_READ:   cmd.mem_read      = 1'b1;
            default:               cmd.commit_drop   = 1'b1;
          endcase
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/tcp_send_window_ring.sv
// ----------------------------------------------------------------------------
// tcp_send_window_ring
// Send window byte ring of one TCP connection: append, read at offset for
// retransmission, and drop of acknowledged bytes, with one result each.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An append, read or drop passes through
// dispatch, a bit-serial modulo unit that reduces every store index against
// the clamped buffer_size one bit per cycle, the update or the registered RAM
// read, and the load of the output register. A rejected append and mode 3 go
// from dispatch straight to the output register load. A new item is taken as
// soon as the previous result is in the output register, even while that
// result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_send_window_ring #(
  parameter int DEPTH = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [tswr_pkg::CNT_W-1:0]  buffer_size,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  mode,
  input  wire logic [tswr_pkg::BYTE_W-1:0] write_byte,
  input  wire logic [tswr_pkg::OFFS_W-1:0] read_offset,
  input  wire logic [tswr_pkg::CNT_W-1:0]  amount,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [tswr_pkg::BYTE_W-1:0] read_data,
  output logic                             accepted,
  output logic      [tswr_pkg::CNT_W-1:0]  stored_count,
  output logic                             full_res,
  output logic                             post_output,
  output logic                             overrun
);

  tswr_pkg::cmd_t  cmd;
  tswr_pkg::stat_t stat;

  tswr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  tswr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .buffer_size  (buffer_size),
    .mode         (mode),
    .write_byte   (write_byte),
    .read_offset  (read_offset),
    .amount       (amount),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .read_data    (read_data),
    .accepted     (accepted),
    .stored_count (stored_count),
    .full_res     (full_res),
    .post_output  (post_output),
    .overrun      (overrun)
  );

endmodule

`default_nettype wire

// File: tb/tb_tcp_send_window_ring.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tcp_send_window_ring
// Self-checking bench for the send window byte ring. A queue of planned
// operations feeds a valid/stall driver, and a monitor checks every result
// against an in-bench model of the ring. The run starts with directed
// appends, reads and drops around empty, full and wrap conditions and a size of
// 0. It then runs random phases under several buffer_size settings, including
// values above the depth. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------

module tb_tcp_send_window_ring;

  localparam int DEPTH          = 4096;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 53;
  localparam int IDLE_PCT       = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    tswr_pkg::mode_t                  mode;
    logic [tswr_pkg::BYTE_W-1:0]      wbyte;
    logic [tswr_pkg::OFFS_W-1:0]      offs;
    logic [tswr_pkg::CNT_W-1:0]       amt;
  } ring_op_t;

  typedef struct packed {
    logic [tswr_pkg::BYTE_W-1:0]  read_data;
    logic                         accepted;
    logic [tswr_pkg::CNT_W-1:0]   stored_count;
    logic                         full;
    logic                         post;
    logic                         overrun;
  } ring_result_t;

  typedef struct packed {
    ring_op_t     op;
    ring_result_t res;
  } ring_xfer_t;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        cfg_we       = 1'b0;
  logic [tswr_pkg::CNT_W-1:0]  buffer_size  = tswr_pkg::BUF_SIZE_RESET;
  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic [1:0]                  mode         = '0;
  logic [tswr_pkg::BYTE_W-1:0] write_byte   = '0;
  logic [tswr_pkg::OFFS_W-1:0] read_offset  = '0;
  logic [tswr_pkg::CNT_W-1:0]  amount       = '0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic [tswr_pkg::BYTE_W-1:0] read_data;
  logic                        accepted;
  logic [tswr_pkg::CNT_W-1:0]  stored_count;
  logic                        full_res;
  logic                        post_output;
  logic                        overrun;

  tcp_send_window_ring #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .buffer_size  (buffer_size),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .write_byte   (write_byte),
    .read_offset  (read_offset),
    .amount       (amount),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .accepted     (accepted),
    .stored_count (stored_count),
    .full_res     (full_res),
    .post_output  (post_output),
    .overrun      (overrun)
  );

  always #5 clk = ~clk;

  // Model of the ring: byte store, indices, count and the size setting.
  logic [tswr_pkg::BYTE_W-1:0] ring_mem    [DEPTH];
  bit                          mem_written [DEPTH];
  int unsigned                 wr_ptr      = 0;
  int unsigned                 rd_ptr      = 0;
  int unsigned                 held        = 0;
  logic [tswr_pkg::CNT_W-1:0]  size_setting = tswr_pkg::BUF_SIZE_RESET;

  ring_xfer_t   pending_ops[$];
  ring_result_t expected_results[$];

  bit calm = 1'b0;
  int failures     = 0;
  int checked      = 0;
  int bytes_stored = 0;
  int saturated    = 0;
  int full_seen    = 0;
  int settings     = 0;
  int idle_cycles  = 0;

  // Out-of-range sizes clamp to the usable range of the store.
  function automatic int unsigned ring_span();
    if (size_setting == 0) return 1;
    if (size_setting > DEPTH) return DEPTH;
    return size_setting;
  endfunction

  function automatic int unsigned read_slot(logic [tswr_pkg::OFFS_W-1:0] offs);
    return ((rd_ptr % ring_span()) + offs) % ring_span();
  endfunction

  function automatic ring_result_t ring_apply(ring_op_t op);
    ring_result_t r;
    int unsigned  span;
    int unsigned  pos;
    int unsigned  drop;
    r    = '0;
    span = ring_span();
    case (op.mode)
      tswr_pkg::MODE_APPEND: begin
        if (held < span) begin
          pos              = wr_ptr % span;
          ring_mem[pos]    = op.wbyte;
          mem_written[pos] = 1'b1;
          wr_ptr           = (pos + 1) % span;
          held++;
          r.accepted       = 1'b1;
        end
      end
      tswr_pkg::MODE_READ: r.read_data = ring_mem[read_slot(op.offs)];
      tswr_pkg::MODE_DROP: begin
        drop = op.amt;
        if (drop > held) begin
          drop      = held;
          r.overrun = 1'b1;
        end
        rd_ptr = ((rd_ptr % span) + drop) % span;
        held   = held - drop;
        r.post = (held > 0);
      end
      default: ;
    endcase
    r.stored_count = tswr_pkg::CNT_W'(held);
    r.full         = (held >= span);
    return r;
  endfunction

  task automatic plan(tswr_pkg::mode_t m, logic [tswr_pkg::BYTE_W-1:0] b,
                      logic [tswr_pkg::OFFS_W-1:0] o, logic [tswr_pkg::CNT_W-1:0] a);
    ring_xfer_t x;
    x.op  = '{mode: m, wbyte: b, offs: o, amt: a};
    x.res = ring_apply(x.op);
    pending_ops.push_back(x);
  endtask

  // Reads only ever target store entries written since reset; when no such
  // offset turns up quickly, the slot becomes an append instead.
  task automatic plan_random();
    tswr_pkg::mode_t             m;
    logic [tswr_pkg::OFFS_W-1:0] o;
    logic [tswr_pkg::CNT_W-1:0]  a;
    int unsigned                 pick;
    int unsigned                 sel;
    bit                          found;
    m     = tswr_pkg::MODE_APPEND;
    o     = tswr_pkg::OFFS_W'($urandom_range(DEPTH - 1));
    a     = tswr_pkg::CNT_W'($urandom_range(DEPTH));
    pick  = $urandom_range(99);
    found = 1'b0;
    if (pick < 30) begin
      for (int t = 0; t < 8 && !found; t++) begin
        if (t[0] && held > 0) o = tswr_pkg::OFFS_W'($urandom_range(held - 1, 0));
        else o = tswr_pkg::OFFS_W'($urandom_range(DEPTH - 1));
        found = mem_written[read_slot(o)];
      end
      if (found) m = tswr_pkg::MODE_READ;
    end else if (pick < 52) begin
      m   = tswr_pkg::MODE_DROP;
      sel = $urandom_range(99);
      if (sel < 60) a = tswr_pkg::CNT_W'($urandom_range(3));
      else if (sel < 82) a = tswr_pkg::CNT_W'($urandom_range(held, 0));
      else if (sel < 95) a = tswr_pkg::CNT_W'($urandom_range(DEPTH, held));
      else a = tswr_pkg::CNT_W'(DEPTH);
    end else if (pick < 56) begin
      m = tswr_pkg::MODE_NONE;
    end
    plan(m, tswr_pkg::BYTE_W'($urandom_range(255)), o, a);
  endtask

  // New sizes go in only while the ring is idle with every result returned.
  task automatic resize(logic [tswr_pkg::CNT_W-1:0] value);
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(negedge clk);
    @(posedge clk);
    cfg_we      <= 1'b1;
    buffer_size <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    size_setting = value;
    settings++;
  endtask

  initial begin
    logic [tswr_pkg::CNT_W-1:0] next_size;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty ring at the reset size: idle mode, zero drop and saturated drop, then appends, reads and drops.
    plan(tswr_pkg::MODE_NONE,   8'h00, '0,        13'd0);
    plan(tswr_pkg::MODE_DROP,   8'h00, '0,        13'd0);
    plan(tswr_pkg::MODE_DROP,   8'h00, '0,        13'd4096);
    plan(tswr_pkg::MODE_APPEND, 8'h00, '0,        13'd0);
    plan(tswr_pkg::MODE_APPEND, 8'hFF, '0,        13'd0);
    plan(tswr_pkg::MODE_APPEND, 8'hA5, '0,        13'd0);
    plan(tswr_pkg::MODE_READ,   8'h00, 12'd0,     13'd0);
    plan(tswr_pkg::MODE_READ,   8'h00, 12'd2,     13'd0);
    plan(tswr_pkg::MODE_DROP,   8'h00, '0,        13'd1);
    plan(tswr_pkg::MODE_DROP,   8'h00, '0,        13'd4096);

    // Shrink the ring to four bytes, then fill past full and
    // read beyond the stored bytes with a wrapping offset.
    resize(13'd4);
    plan(tswr_pkg::MODE_APPEND, 8'h5A, '0,        13'd0);
    plan(tswr_pkg::MODE_APPEND, 8'h3C, '0,        13'd0);
    plan(tswr_pkg::MODE_APPEND, 8'hC3, '0,        13'd0);
    plan(tswr_pkg::MODE_APPEND, 8'h81, '0,        13'd0);
    plan(tswr_pkg::MODE_APPEND, 8'h7E, '0,        13'd0);
    plan(tswr_pkg::MODE_NONE,   8'h00, '0,        13'd0);
    plan(tswr_pkg::MODE_READ,   8'h00, 12'd4095,  13'd0);
    plan(tswr_pkg::MODE_READ,   8'h00, 12'd6,     13'd0);
    plan(tswr_pkg::MODE_DROP,   8'h00, '0,        13'd3);
    plan(tswr_pkg::MODE_READ,   8'h00, 12'd0,     13'd0);
    plan(tswr_pkg::MODE_DROP,   8'h00, '0,        13'd2);

    // A size of zero behaves as a one-byte ring.
    resize(13'd0);
    plan(tswr_pkg::MODE_APPEND, 8'h55, '0,        13'd0);
    plan(tswr_pkg::MODE_APPEND, 8'hAA, '0,        13'd0);
    plan(tswr_pkg::MODE_READ,   8'h00, 12'd4095,  13'd0);
    plan(tswr_pkg::MODE_DROP,   8'h00, '0,        13'd1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: next_size = 13'd8191;
        1: next_size = 13'd16;
        2: next_size = 13'd1;
        3: next_size = tswr_pkg::CNT_W'($urandom_range(64, 2));
        4: next_size = 13'd4097;
        5: next_size = tswr_pkg::CNT_W'($urandom_range(DEPTH, 1));
        6: next_size = 13'd4096;
        7: next_size = 13'd2;
        default: next_size = tswr_pkg::CNT_W'($urandom_range(300, 17));
      endcase
      resize(next_size);
      calm = (p == 5);
      repeat (PHASE_ITEMS) plan_random();
    end

    while (pending_ops.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d results checked under %0d size settings: %0d bytes stored,",
             checked, settings, bytes_stored);
    $display("%0d saturated drops, %0d results at full", saturated, full_seen);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Driver: a presented operation holds until its transfer completes.
  always @(posedge clk) begin : drive_ops
    ring_xfer_t nxt;
    bit         show;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(pending_ops[0].res);
        void'(pending_ops.pop_front());
      end
      if (!in_valid || !in_stall) begin
        show = pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT);
        in_valid <= show;
        if (show) begin
          nxt = pending_ops[0];
          mode        <= nxt.op.mode;
          write_byte  <= nxt.op.wbyte;
          read_offset <= nxt.op.offs;
          amount      <= nxt.op.amt;
        end
      end
    end
  end

  // Monitor: each result transfer is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    ring_result_t got;
    ring_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{read_data: read_data, accepted: accepted, stored_count: stored_count,
                full: full_res, post: post_output, overrun: overrun};
        if (expected_results.size() == 0) begin
          if (failures < REPORT_LIMIT)
            $display("%0t: result with nothing outstanding (count %0d)", $realtime,
                     stored_count);
          failures++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          bytes_stored += want.accepted;
          saturated    += want.overrun;
          full_seen    += want.full;
          if (got !== want) begin
            if (failures < REPORT_LIMIT) begin
              $display("%0t: expected data %h acc %b count %0d full %b post %b ovr %b",
                       $realtime, want.read_data, want.accepted, want.stored_count,
                       want.full, want.post, want.overrun);
              $display("%0t:      got data %h acc %b count %0d full %b post %b ovr %b",
                       $realtime, got.read_data, got.accepted, got.stored_count,
                       got.full, got.post, got.overrun);
            end
            failures++;
          end
        end
      end
      out_stall <= !calm && $urandom_range(99) < IDLE_PCT;
    end
  end

  // Watchdog on cycles without any transfer on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: files.f
rtl/core/tswr_pkg.sv
rtl/core/tswr_ram.sv
rtl/core/tswr_mod.sv
rtl/core/tswr_dp.sv
rtl/core/tswr_ctrl.sv
rtl/core/tcp_send_window_ring.sv
tb/tb_tcp_send_window_ring.sv
